FILE: rtl/core/bf3_pkg.sv
`timescale 1ns / 1ps

package bf3_pkg;

  localparam int PIXEL_BITS   = 8;
  localparam int MAX_SIDE_DEF = 1024;
  localparam int SIDE_W       = 11;
  localparam int RC_W         = 10;
  localparam logic [SIDE_W-1:0] SIDE_RESET = SIDE_W'(8);

  // sum of up to nine pixels
  localparam int SUM_W = PIXEL_BITS + 4;

  // reciprocals scaled by 2^RECIP_SHIFT, exact for sums below 4096
  localparam int RECIP_SHIFT = 15;
  localparam int RECIP_W     = 14;
  localparam logic [RECIP_W-1:0] RECIP_4 = RECIP_W'(8192);
  localparam logic [RECIP_W-1:0] RECIP_6 = RECIP_W'(5462);
  localparam logic [RECIP_W-1:0] RECIP_9 = RECIP_W'(3641);

  // result kinds, in emission order
  localparam logic [1:0] RES_UL = 2'd0;  // (r-1, c-1)
  localparam logic [1:0] RES_UR = 2'd1;  // (r-1, c)
  localparam logic [1:0] RES_LL = 2'd2;  // (r, c-1)
  localparam logic [1:0] RES_LR = 2'd3;  // (r, c)

  typedef struct packed {
    logic       accept;
    logic       shift;
    logic       sum_en;
    logic       mul_en;
    logic [1:0] sel;
    logic       last;
  } bf3_cmd_t;

  typedef struct packed {
    logic [3:0] flags;
    logic       out_full;
  } bf3_sts_t;

endpackage

FILE: rtl/core/box_filter_3x3_edge_aware_top.sv
`timescale 1ns / 1ps
// channel  | handshake                 | words
// input    | in_valid / in_ready       | pixel_in
// output   | out_valid / out_ready     | smoothed_value, out_row, out_col, run_last, frame_done
// config   | cfg_wr_en (no wait)       | cfg_wr_data (image_side)
//
// Each pixel runs through a line store read, a window shift with store write, then a
// sum step and a multiply step per result it causes (0 to 4 results), in the shared
// sum/reciprocal-multiply unit; a new pixel is taken only once its results are loaded.
// Synchronous active-high rst: side = 8, counters and window cleared; line stores
// hold old data that is never used. A stalled output holds the multiply step.

module box_filter_3x3_edge_aware_top #(
  parameter int MAX_SIDE = bf3_pkg::MAX_SIDE_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [bf3_pkg::SIDE_W-1:0] cfg_wr_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 pixel_in,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [7:0]                 smoothed_value,
  output logic [bf3_pkg::RC_W-1:0]   out_row,
  output logic [bf3_pkg::RC_W-1:0]   out_col,
  output logic                       run_last,
  output logic                       frame_done
);

  bf3_pkg::bf3_cmd_t cmd;
  bf3_pkg::bf3_sts_t sts;

  bf3_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bf3_dp #(
    .MAX_SIDE (MAX_SIDE)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .pixel_in       (pixel_in),
    .out_ready      (out_ready),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_valid),
    .smoothed_value (smoothed_value),
    .out_row        (out_row),
    .out_col        (out_col),
    .run_last       (run_last),
    .frame_done     (frame_done)
  );

endmodule

FILE: rtl/core/bf3_ctrl.sv
`timescale 1ns / 1ps

module bf3_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               out_ready,
  input  bf3_pkg::bf3_sts_t  sts,
  output bf3_pkg::bf3_cmd_t  cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SHIFT = 3'd1;
  localparam logic [2:0] ST_SUM   = 3'd2;
  localparam logic [2:0] ST_MUL   = 3'd3;

  logic [2:0] state, state_next;
  logic [3:0] pend, pend_next;
  logic [1:0] sel;
  logic [3:0] sel_bit;
  logic       can_load;

  always_comb begin
    if (pend[0]) begin
      sel = bf3_pkg::RES_UL;
    end else if (pend[1]) begin
      sel = bf3_pkg::RES_UR;
    end else if (pend[2]) begin
      sel = bf3_pkg::RES_LL;
    end else begin
      sel = bf3_pkg::RES_LR;
    end
  end

  assign sel_bit  = 4'b0001 << sel;
  assign can_load = !sts.out_full || out_ready;
  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    pend_next  = pend;
    cmd        = '0;
    cmd.sel    = sel;
    cmd.last   = ((pend & ~sel_bit) == 4'b0000);
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        cmd.shift  = 1'b1;
        state_next = ST_SUM;
      end
      ST_SUM: begin
        // flags are settled once the shift is done
        if (pend == 4'b0000 && sts.flags == 4'b0000) begin
          state_next = ST_IDLE;
        end else begin
          if (pend == 4'b0000) begin
            pend_next = sts.flags;
          end else begin
            cmd.sum_en = 1'b1;
            state_next = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        if (can_load) begin
          cmd.mul_en = 1'b1;
          pend_next  = pend & ~sel_bit;
          state_next = ((pend & ~sel_bit) == 4'b0000) ? ST_IDLE : ST_SUM;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pend  <= '0;
    end else begin
      state <= state_next;
      pend  <= pend_next;
    end
  end

endmodule

FILE: rtl/core/bf3_dp.sv
`timescale 1ns / 1ps

module bf3_dp #(
  parameter int MAX_SIDE = bf3_pkg::MAX_SIDE_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [bf3_pkg::SIDE_W-1:0]     cfg_wr_data,
  input  logic [7:0]                     pixel_in,
  input  logic                           out_ready,
  input  bf3_pkg::bf3_cmd_t              cmd,
  output bf3_pkg::bf3_sts_t              sts,
  output logic                           out_valid,
  output logic [7:0]                     smoothed_value,
  output logic [bf3_pkg::RC_W-1:0]       out_row,
  output logic [bf3_pkg::RC_W-1:0]       out_col,
  output logic                           run_last,
  output logic                           frame_done
);

  localparam int AW = (MAX_SIDE > 2) ? $clog2(MAX_SIDE) : 1;
  localparam int SW = $clog2(MAX_SIDE + 1);
  localparam int PB = bf3_pkg::PIXEL_BITS;
  localparam int PW = bf3_pkg::SUM_W + bf3_pkg::RECIP_W;

  logic [bf3_pkg::SIDE_W-1:0] image_side;
  logic [SW-1:0]              side_eff;
  logic [AW-1:0]              last_idx;
  logic [AW-1:0]              row_cnt, col_cnt, r_eff, c_eff;
  logic [AW-1:0]              cur_r, cur_c;
  logic [PB-1:0]              pix_q;
  logic [PB-1:0]              older_line [MAX_SIDE];
  logic [PB-1:0]              prior_line [MAX_SIDE];
  logic [PB-1:0]              rd_older, rd_prior;
  logic [PB-1:0]              win [9];

  logic                       up_sel, left_sel, row0_en, col0_en;
  logic [bf3_pkg::SUM_W-1:0]  sum_c, sum_q;
  logic [bf3_pkg::RECIP_W-1:0] recip_c, recip_q;
  logic [AW-1:0]              crow, ccol, crow_q, ccol_q;
  logic                       last_q, done_q;
  logic [PW-1:0]              prod;

  always_comb begin
    if (image_side < bf3_pkg::SIDE_W'(2)) begin
      side_eff = SW'(2);
    end else if (32'(image_side) > MAX_SIDE) begin
      side_eff = SW'(MAX_SIDE);
    end else begin
      side_eff = SW'(image_side);
    end
  end

  assign last_idx = AW'(side_eff - SW'(1));
  // counters past the side restart the frame
  assign r_eff = (SW'(row_cnt) >= side_eff || SW'(col_cnt) >= side_eff) ? '0 : row_cnt;
  assign c_eff = (SW'(row_cnt) >= side_eff || SW'(col_cnt) >= side_eff) ? '0 : col_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_side <= bf3_pkg::SIDE_RESET;
      row_cnt    <= '0;
      col_cnt    <= '0;
    end else if (cfg_wr_en) begin
      image_side <= cfg_wr_data;
      row_cnt    <= '0;
      col_cnt    <= '0;
    end else if (cmd.accept) begin
      if (c_eff == last_idx) begin
        col_cnt <= '0;
        row_cnt <= (r_eff == last_idx) ? '0 : r_eff + AW'(1);
      end else begin
        col_cnt <= c_eff + AW'(1);
        row_cnt <= r_eff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cur_r    <= r_eff;
      cur_c    <= c_eff;
      pix_q    <= pixel_in[PB-1:0];
      rd_older <= older_line[c_eff];
      rd_prior <= prior_line[c_eff];
    end
    if (cmd.shift) begin
      older_line[cur_c] <= rd_prior;
      prior_line[cur_c] <= pix_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 9; i++) begin
        win[i] <= '0;
      end
    end else if (cmd.shift) begin
      win[0] <= win[1]; win[1] <= win[2]; win[2] <= rd_older;
      win[3] <= win[4]; win[4] <= win[5]; win[5] <= rd_prior;
      win[6] <= win[7]; win[7] <= win[8]; win[8] <= pix_q;
    end
  end

  assign sts.flags[0] = (cur_r != '0) && (cur_c != '0);
  assign sts.flags[1] = (cur_r != '0) && (cur_c == last_idx);
  assign sts.flags[2] = (cur_r == last_idx) && (cur_c != '0);
  assign sts.flags[3] = (cur_r == last_idx) && (cur_c == last_idx);
  assign sts.out_full = out_valid;

  // window rows are r-2..r, columns c-2..c; the oldest row/column only counts
  // when the center sits one back and that row/column is inside the image
  assign up_sel   = (cmd.sel == bf3_pkg::RES_UL) || (cmd.sel == bf3_pkg::RES_UR);
  assign left_sel = (cmd.sel == bf3_pkg::RES_UL) || (cmd.sel == bf3_pkg::RES_LL);
  assign row0_en  = up_sel && (cur_r > AW'(1));
  assign col0_en  = left_sel && (cur_c > AW'(1));
  assign crow     = up_sel ? cur_r - AW'(1) : cur_r;
  assign ccol     = left_sel ? cur_c - AW'(1) : cur_c;

  always_comb begin
    sum_c = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if ((i != 0 || row0_en) && (j != 0 || col0_en)) begin
          sum_c = sum_c + bf3_pkg::SUM_W'(win[i*3+j]);
        end
      end
    end
    if (row0_en && col0_en) begin
      recip_c = bf3_pkg::RECIP_9;
    end else if (row0_en || col0_en) begin
      recip_c = bf3_pkg::RECIP_6;
    end else begin
      recip_c = bf3_pkg::RECIP_4;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sum_en) begin
      sum_q   <= sum_c;
      recip_q <= recip_c;
      crow_q  <= crow;
      ccol_q  <= ccol;
      last_q  <= cmd.last;
      done_q  <= (cmd.sel == bf3_pkg::RES_LR);
    end
  end

  assign prod = PW'(sum_q) * PW'(recip_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.mul_en) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      smoothed_value <= 8'(prod[bf3_pkg::RECIP_SHIFT +: PB]);
      out_row        <= bf3_pkg::RC_W'(crow_q);
      out_col        <= bf3_pkg::RC_W'(ccol_q);
      run_last       <= last_q;
      frame_done     <= done_q;
    end
  end

endmodule

FILE: tb/tb_box_filter_3x3_edge_aware_top.sv
`timescale 1ns / 1ps

module tb_box_filter_3x3_edge_aware_top;

  localparam int SIDE_MAX = 1024;

  typedef struct {
    logic [7:0]               value;
    logic [bf3_pkg::RC_W-1:0] row;
    logic [bf3_pkg::RC_W-1:0] col;
    logic                     last;
    logic                     done;
  } blur_word_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_wr_en = 1'b0;
  logic [bf3_pkg::SIDE_W-1:0] cfg_wr_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [7:0]                 pixel_in = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [7:0]                 smoothed_value;
  logic [bf3_pkg::RC_W-1:0]   out_row;
  logic [bf3_pkg::RC_W-1:0]   out_col;
  logic                       run_last;
  logic                       frame_done;

  // blur model state
  logic [bf3_pkg::SIDE_W-1:0] side_reg;
  logic [7:0]        line_older[SIDE_MAX];
  logic [7:0]        line_prior[SIDE_MAX];
  logic [7:0]        win[9];
  int                cur_row;
  int                cur_col;

  logic [7:0]  pix_q[$];
  blur_word_t  blur_q[$];
  int          err_cnt = 0;
  int          send_gap = 0;
  int          recv_gap = 0;
  int          hold_left = 0;
  logic        hold_req = 1'b0;
  logic        hold_done = 1'b0;
  logic        no_idle = 1'b0;

  box_filter_3x3_edge_aware_top u_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .pixel_in       (pixel_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .smoothed_value (smoothed_value),
    .out_row        (out_row),
    .out_col        (out_col),
    .run_last       (run_last),
    .frame_done     (frame_done)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int eff_side();
    if (side_reg < 2) return 2;
    if (side_reg > SIDE_MAX) return SIDE_MAX;
    return int'(side_reg);
  endfunction

  // mean around (cr, cc); window spans rows r-2..r, cols c-2..c
  function automatic logic [7:0] nbr_mean(int cr, int cc, int r, int c, int s);
    int sum, cnt, rr, cl, wi, wj;
    sum = 0;
    cnt = 0;
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        rr = cr + dr;
        cl = cc + dc;
        wi = rr - (r - 2);
        wj = cl - (c - 2);
        if (rr >= 0 && rr < s && cl >= 0 && cl < s && wi >= 0 && wi <= 2 &&
            wj >= 0 && wj <= 2) begin
          sum += win[wi * 3 + wj];
          cnt++;
        end
      end
    end
    if (cnt == 0) return '0;
    return 8'(sum / cnt);
  endfunction

  task automatic push_blur(logic [7:0] v, int r, int c, logic done, ref int n);
    blur_word_t w;
    w.value = v;
    w.row   = bf3_pkg::RC_W'(r);
    w.col   = bf3_pkg::RC_W'(c);
    w.last  = 1'b0;
    w.done  = done;
    blur_q.push_back(w);
    n++;
  endtask

  task automatic blur_pixel(logic [7:0] pix);
    int s, r, c, n;
    logic [7:0] up2, up1;
    s = eff_side();
    n = 0;
    if (cur_row >= s || cur_col >= s) begin
      cur_row = 0;
      cur_col = 0;
    end
    r = cur_row;
    c = cur_col;
    up2 = line_older[c];
    up1 = line_prior[c];
    win[0] = win[1]; win[1] = win[2]; win[2] = up2;
    win[3] = win[4]; win[4] = win[5]; win[5] = up1;
    win[6] = win[7]; win[7] = win[8]; win[8] = pix;
    line_older[c] = up1;
    line_prior[c] = pix;
    if (r >= 1 && c >= 1) push_blur(nbr_mean(r - 1, c - 1, r, c, s), r - 1, c - 1, 1'b0, n);
    if (r >= 1 && c == s - 1) push_blur(nbr_mean(r - 1, c, r, c, s), r - 1, c, 1'b0, n);
    if (r == s - 1 && c >= 1) push_blur(nbr_mean(r, c - 1, r, c, s), r, c - 1, 1'b0, n);
    if (r == s - 1 && c == s - 1) push_blur(nbr_mean(r, c, r, c, s), r, c, 1'b1, n);
    if (n > 0) blur_q[blur_q.size() - 1].last = 1'b1;
    c++;
    if (c >= s) begin
      c = 0;
      r++;
      if (r >= s) r = 0;
    end
    cur_row = r;
    cur_col = c;
  endtask

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 9);
    if (no_idle || p < 6) return 0;
    if (p < 9) return $urandom_range(1, 3);
    return $urandom_range(5, 25);
  endfunction

  // driver
  always @(posedge clk) begin : drv
    logic busy;
    busy = 1'b0;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      busy = in_valid && !in_ready;
      if (in_valid && in_ready) blur_pixel(pixel_in);
      if (!busy) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pix_q.size() != 0) begin
          in_valid <= 1'b1;
          pixel_in <= pix_q.pop_front();
          send_gap = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin : mon
    blur_word_t w;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (blur_q.size() == 0) begin
          $error("unexpected word row %0d col %0d", out_row, out_col);
          err_cnt++;
        end else begin
          w = blur_q.pop_front();
          if (smoothed_value !== w.value) begin
            $error("smoothed_value exp %0d got %0d", w.value, smoothed_value);
            err_cnt++;
          end
          if (out_row !== w.row) begin
            $error("out_row exp %0d got %0d", w.row, out_row);
            err_cnt++;
          end
          if (out_col !== w.col) begin
            $error("out_col exp %0d got %0d", w.col, out_col);
            err_cnt++;
          end
          if (run_last !== w.last) begin
            $error("run_last exp %0d got %0d", w.last, run_last);
            err_cnt++;
          end
          if (frame_done !== w.done) begin
            $error("frame_done exp %0d got %0d", w.done, frame_done);
            err_cnt++;
          end
        end
      end
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        recv_gap = pick_gap();
      end
    end
  end

  task automatic drain();
    while (pix_q.size() != 0 || in_valid || blur_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);  // zero-result pixels may still be in flight
  endtask

  task automatic write_side(logic [bf3_pkg::SIDE_W-1:0] v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    side_reg = v;
    cur_row  = 0;
    cur_col  = 0;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic send_rand(int n);
    for (int i = 0; i < n; i++) pix_q.push_back(8'($urandom_range(0, 255)));
  endtask

  initial begin
    int sent, s, n;
    side_reg = bf3_pkg::SIDE_RESET;
    cur_row  = 0;
    cur_col  = 0;
    for (int i = 0; i < 9; i++) win[i] = '0;
    for (int i = 0; i < SIDE_MAX; i++) begin
      line_older[i] = '0;
      line_prior[i] = '0;
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // side zero clamps to 2: all-max then mixed corners
    write_side('0);
    pix_q = '{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd255};
    drain();
    // side one clamps to 2
    write_side(bf3_pkg::SIDE_W'(1));
    pix_q = '{8'd0, 8'd0, 8'd0, 8'd1};
    drain();
    // side 3: corners, edges and a center
    write_side(bf3_pkg::SIDE_W'(3));
    pix_q = '{8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd128, 8'd1};
    drain();

    // oversized side clamps to the maximum; broken frame
    write_side('1);
    send_rand(20);
    drain();

    sent = 0;
    while (sent < 60) begin
      s = $urandom_range(2, 8);
      write_side(bf3_pkg::SIDE_W'(s));
      no_idle = ($urandom_range(0, 3) == 0);
      if (!hold_done) begin
        // a frame plus a row so the sender keeps offering while stalled
        hold_req = 1'b1;
        n = s * s + s;
      end else if ($urandom_range(0, 4) == 0) begin
        n = $urandom_range(1, s * s - 1);
      end else begin
        n = s * s;
      end
      send_rand(n);
      sent += n;
      drain();
    end
    no_idle = 1'b0;
    // default side again for the reset value
    write_side(bf3_pkg::SIDE_RESET);
    send_rand(64);
    drain();
    repeat (30) @(posedge clk);
    if (err_cnt == 0 && blur_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
